### hw/rtl/vpid_pkg.sv
// ----------------------------------------------------------------------------
// vpid_pkg
// Shared widths, constants and state codes of the velocity PID controller.
// ----------------------------------------------------------------------------
package vpid_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 31;
  localparam int CMD_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int INTEG_W   = 48;

  // shared multiplier datapath
  localparam int OPA_W   = 61;               // operand A, holds up to the product cap
  localparam int OPB_W   = 32;
  localparam int PROD_W  = 64;
  localparam int HI_W    = OPA_W - 32;
  localparam int FULL_W  = OPA_W + OPB_W;
  localparam int SGN_W   = OPA_W + 1;        // signed product after sign applied
  localparam int SUM_W   = 64;
  localparam int ITERM_W = FRAC_BITS + 9;

  localparam logic [OPA_W-1:0]  PROD_CAP = OPA_W'(1) << 60;
  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
  localparam logic signed [ITERM_W-1:0] I_CLAMP = ITERM_W'(200) << FRAC_BITS;
  localparam int PWM_LIMIT = 400;

  localparam logic [DATA_W-1:0] PERIOD_RESET = DATA_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [DATA_W-1:0] RATE_RESET   = DATA_W'(100 << FRAC_BITS);
  localparam logic [GAIN_W-1:0] SCALE_RESET  = GAIN_W'(1 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_TICK_PERIOD = 3'd3,
    REG_TICK_RATE   = 3'd4,
    REG_COUNT_SCALE = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_FIN,
    S_POST,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    ST_VEL1,
    ST_VEL2,
    ST_ERR,
    ST_P0,
    ST_P,
    ST_ITG,
    ST_I0,
    ST_I,
    ST_D1,
    ST_D2,
    ST_SUM,
    ST_CMD
  } step_t;

endpackage

### hw/rtl/vpid_channels.sv
// ----------------------------------------------------------------------------
// vpid channels
// Valid/ready channels of the velocity PID controller: tick, drive and config.
// ----------------------------------------------------------------------------
interface vpid_tick_if import vpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] encoder_count;
  logic signed [DATA_W-1:0] target_velocity;

  modport source (output valid, encoder_count, target_velocity, input ready);
  modport sink   (input valid, encoder_count, target_velocity, output ready);
endinterface

interface vpid_drive_if import vpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CMD_W-1:0]  motor_command;
  logic signed [DATA_W-1:0] measured_velocity;
  logic signed [DATA_W-1:0] velocity_error;

  modport source (output valid, motor_command, measured_velocity, velocity_error,
                  input ready);
  modport sink   (input valid, motor_command, measured_velocity, velocity_error,
                  output ready);
endinterface

interface vpid_cfg_if import vpid_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/velocity_pid_controller_core.sv
// ----------------------------------------------------------------------------
// velocity_pid_controller_core
// Velocity PID loop with clamped integrator, one drive command per tick.
// ----------------------------------------------------------------------------
// tick  : request carries encoder_count and target_velocity (Q16.16).
// drive : result carries motor_command (+/-400), measured_velocity and
//         velocity_error (both saturated Q16.16).
// cfg   : register writes, index 0..5 (gains, period, rate, count scale);
//         always ready, other indexes ignored. Write only while idle.
// One request is in flight at a time. tick.ready is high only when idle.
// The work is a sequence of seven fixed-point multiplies on one shared 32x32
// multiplier, each a low pass, a high pass only when operand A exceeds 32 bits,
// and a finish, plus twelve update steps; the result is then shown on drive.
// It is held there until taken; the cycle after that the block is ready again,
// so a new tick is accepted only after the last result has been taken.
// A stalled receiver simply holds the block in its output state.
// Reset (rst, synchronous) restores the register defaults and clears the
// stored count, stored error and integrator.
// ----------------------------------------------------------------------------
module velocity_pid_controller_core import vpid_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  vpid_tick_if.sink     tick,
  vpid_drive_if.source  drive,
  vpid_cfg_if.sink      cfg
);

  state_t state, state_next;
  step_t  step, step_next;

  // configuration
  logic [GAIN_W-1:0] prop_gain, integ_gain, deriv_gain, count_scale;
  logic [DATA_W-1:0] tick_period, tick_rate;

  // architectural state
  logic signed [DATA_W-1:0]  last_count, last_error;
  logic signed [INTEG_W-1:0] integral;

  // datapath
  logic signed [DATA_W-1:0]  count_in, target;
  logic signed [DATA_W-1:0]  vel, err;
  logic signed [SGN_W-1:0]   p_term, d_term;
  logic signed [ITERM_W-1:0] i_term;
  logic signed [SUM_W-1:0]   sum;
  logic signed [CMD_W-1:0]   cmd;

  // shared multiplier
  logic [OPA_W-1:0]  op_a;
  logic [OPB_W-1:0]  op_b;
  logic              op_neg;
  logic [PROD_W-1:0] lo_prod;
  logic [OPA_W-1:0]  hi_prod;
  logic [OPA_W-1:0]  mres;

  logic [31:0]        mul_a;
  logic [PROD_W-1:0]  mul_p;
  logic [FULL_W-1:0]  full, shifted;
  logic [OPA_W-1:0]   mres_next;
  logic signed [SGN_W-1:0] mres_s;

  logic signed [DATA_W:0]    diff;
  logic [DATA_W:0]           diff_mag;
  logic [DATA_W-1:0]         vel_next;
  logic signed [DATA_W:0]    err_wide;
  logic [DATA_W-1:0]         err_next;
  logic [DATA_W-1:0]         err_mag;
  logic signed [DATA_W:0]    ediff;
  logic [DATA_W:0]           ediff_mag;
  logic [INTEG_W-1:0]        integ_mag;
  logic signed [SGN_W-1:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [ITERM_W-1:0] i_clamped;
  logic signed [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]          sum_mag, sum_q;
  logic [CMD_W-1:0]          cmd_mag;
  logic signed [CMD_W-1:0]   cmd_next;

  // ---------------- multiplier ----------------
  assign mul_a = (state == S_MUL_HI) ? 32'(op_a[OPA_W-1:32]) : op_a[31:0];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(op_b);

  assign full      = {hi_prod, 32'b0} + FULL_W'(lo_prod);
  assign shifted   = full >> FRAC_BITS;
  assign mres_next = (shifted > FULL_W'(PROD_CAP)) ? PROD_CAP : shifted[OPA_W-1:0];
  assign mres_s    = op_neg ? -$signed({1'b0, mres}) : $signed({1'b0, mres});

  // ---------------- step arithmetic ----------------
  always_comb begin
    diff     = $signed({tick.encoder_count[DATA_W-1], tick.encoder_count})
             - $signed({last_count[DATA_W-1], last_count});
    diff_mag = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);

    if (op_neg) begin
      vel_next = (mres > OPA_W'(DATA_MIN)) ? DATA_MIN : -mres[DATA_W-1:0];
    end else begin
      vel_next = (mres > OPA_W'(DATA_MAX)) ? DATA_MAX : mres[DATA_W-1:0];
    end

    err_wide = $signed({target[DATA_W-1], target}) - $signed({vel[DATA_W-1], vel});
    if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
      err_next = err_wide[DATA_W] ? DATA_MIN : DATA_MAX;
    end else begin
      err_next = err_wide[DATA_W-1:0];
    end
    err_mag = err[DATA_W-1] ? DATA_W'(-err) : DATA_W'(err);

    ediff     = $signed({err[DATA_W-1], err}) - $signed({last_error[DATA_W-1], last_error});
    ediff_mag = ediff[DATA_W] ? (DATA_W+1)'(-ediff) : (DATA_W+1)'(ediff);

    integ_mag = integral[INTEG_W-1] ? INTEG_W'(-integral) : INTEG_W'(integral);
    integ_sum = SGN_W'(integral) + mres_s;
    // fits when every bit above the 48-bit sign matches it
    if (integ_sum[SGN_W-1:INTEG_W-1] != {(SGN_W-INTEG_W+1){integ_sum[SGN_W-1]}}) begin
      integ_sat = integ_sum[SGN_W-1] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end

    if (mres_s > SGN_W'(I_CLAMP)) begin
      i_clamped = I_CLAMP;
    end else if (mres_s < -SGN_W'(I_CLAMP)) begin
      i_clamped = -I_CLAMP;
    end else begin
      i_clamped = mres_s[ITERM_W-1:0];
    end

    sum_next = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
    sum_mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    sum_q    = sum_mag >> FRAC_BITS;
    cmd_mag  = (sum_q > SUM_W'(PWM_LIMIT)) ? CMD_W'(PWM_LIMIT) : sum_q[CMD_W-1:0];
    cmd_next = sum[SUM_W-1] ? -$signed(cmd_mag) : $signed(cmd_mag);
  end

  // ---------------- sequencer ----------------
  always_comb begin
    unique case (step)
      ST_VEL1: step_next = ST_VEL2;
      ST_VEL2: step_next = ST_ERR;
      ST_ERR:  step_next = ST_P0;
      ST_P0:   step_next = ST_P;
      ST_P:    step_next = ST_ITG;
      ST_ITG:  step_next = ST_I0;
      ST_I0:   step_next = ST_I;
      ST_I:    step_next = ST_D1;
      ST_D1:   step_next = ST_D2;
      ST_D2:   step_next = ST_SUM;
      ST_SUM:  step_next = ST_CMD;
      ST_CMD:  step_next = ST_VEL1;
      default: step_next = ST_VEL1;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (tick.valid) state_next = S_MUL_LO;
      S_MUL_LO:  state_next = (op_a[OPA_W-1:32] != '0) ? S_MUL_HI : S_MUL_FIN;
      S_MUL_HI:  state_next = S_MUL_FIN;
      S_MUL_FIN: state_next = S_POST;
      S_POST: begin
        unique case (step)
          ST_VEL1, ST_P0, ST_P, ST_I0, ST_I, ST_D1: state_next = S_MUL_LO;
          ST_CMD:  state_next = S_OUT;
          default: state_next = S_POST;
        endcase
      end
      S_OUT:     if (drive.ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tick.ready              = (state == S_IDLE);
    drive.valid             = (state == S_OUT);
    drive.motor_command     = cmd;
    drive.measured_velocity = vel;
    drive.velocity_error    = err;
    cfg.ready               = 1'b1;
  end

  // ---------------- control and state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= ST_VEL1;
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      tick_period <= PERIOD_RESET;
      tick_rate   <= RATE_RESET;
      count_scale <= SCALE_RESET;
      last_count  <= '0;
      last_error  <= '0;
      integral    <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        step <= ST_VEL1;
      end else if (state == S_POST) begin
        step <= step_next;
      end

      if (cfg.valid) begin
        unique case (cfg.index)
          REG_PROP_GAIN:   prop_gain   <= cfg.data[GAIN_W-1:0];
          REG_INTEG_GAIN:  integ_gain  <= cfg.data[GAIN_W-1:0];
          REG_DERIV_GAIN:  deriv_gain  <= cfg.data[GAIN_W-1:0];
          REG_TICK_PERIOD: tick_period <= cfg.data;
          REG_TICK_RATE:   tick_rate   <= cfg.data;
          REG_COUNT_SCALE: count_scale <= cfg.data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (state == S_POST) begin
        if (step == ST_ITG) integral <= integ_sat;
        if (step == ST_CMD) begin
          last_count <= count_in;
          last_error <= err;
        end
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (tick.valid) begin
          count_in <= tick.encoder_count;
          target   <= tick.target_velocity;
          op_a     <= OPA_W'(diff_mag) << FRAC_BITS;
          op_b     <= tick_rate;
          op_neg   <= diff[DATA_W];
        end
      end
      S_MUL_LO: begin
        lo_prod <= mul_p;
        hi_prod <= '0;
      end
      S_MUL_HI:  hi_prod <= mul_p[OPA_W-1:0];
      S_MUL_FIN: mres    <= mres_next;
      S_POST: begin
        unique case (step)
          ST_VEL1: begin
            op_a <= mres;
            op_b <= OPB_W'(count_scale);
          end
          ST_VEL2: vel <= vel_next;
          ST_ERR:  err <= err_next;
          ST_P0: begin
            op_a   <= OPA_W'(err_mag);
            op_b   <= OPB_W'(prop_gain);
            op_neg <= err[DATA_W-1];
          end
          ST_P: begin
            p_term <= mres_s;
            op_a   <= OPA_W'(err_mag);
            op_b   <= tick_period;
          end
          ST_ITG: ;
          ST_I0: begin
            op_a   <= OPA_W'(integ_mag);
            op_b   <= OPB_W'(integ_gain);
            op_neg <= integral[INTEG_W-1];
          end
          ST_I: begin
            i_term <= i_clamped;
            op_a   <= OPA_W'(ediff_mag);
            op_b   <= tick_rate;
            op_neg <= ediff[DATA_W];
          end
          ST_D1: begin
            op_a <= mres;
            op_b <= OPB_W'(deriv_gain);
          end
          ST_D2:   d_term <= mres_s;
          ST_SUM:  sum    <= sum_next;
          ST_CMD:  cmd    <= cmd_next;
          default: ;
        endcase
      end
      S_OUT: ;
      default: ;
    endcase
  end

endmodule

### hw/rtl/vpid_checker.sv
// ----------------------------------------------------------------------------
// vpid_checker
// Port-level checks on the velocity PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module vpid_checker import vpid_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    tick_valid,
  input logic                    tick_ready,
  input logic                    drive_valid,
  input logic                    drive_ready,
  input logic signed [CMD_W-1:0] motor_command
);

  // a pending result is held until taken
  a_drive_hold: assert property (@(posedge clk) disable iff (rst)
    drive_valid && !drive_ready |=> drive_valid)
    else $error("drive result dropped while stalled");

  // one request at a time: no new request while a result is shown
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(tick_ready && drive_valid))
    else $error("tick ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready && !drive_valid)
    else $error("block not busy after accepting a request");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    drive_valid && drive_ready |=> !drive_valid)
    else $error("result repeated");

  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> (motor_command <= CMD_W'(PWM_LIMIT)) &&
                    (motor_command >= -CMD_W'(PWM_LIMIT)))
    else $error("motor command outside PWM range");

endmodule

bind velocity_pid_controller_core vpid_checker u_vpid_checker (
  .clk           (clk),
  .rst           (rst),
  .tick_valid    (tick.valid),
  .tick_ready    (tick.ready),
  .drive_valid   (drive.valid),
  .drive_ready   (drive.ready),
  .motor_command (drive.motor_command)
);
